FILE: sv/aqtf_pkg.sv
// ---------------------------------------------------------------------------
// aqtf_pkg
// Shared types and constants of the quantile trim filter.
// ---------------------------------------------------------------------------
package aqtf_pkg;

   // Register indexes of the configuration port.
   localparam logic [0:0] REG_AXIS  = 1'd0;
   localparam logic [0:0] REG_RATIO = 1'd1;

   localparam logic [15:0] RATIO_RESET = 16'd32768;

   // One stored point: x, y, z and tag.
   typedef struct packed {
      logic [31:0] tag;
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } point_type;

   // Order-preserving key of a signed coordinate on the selected axis.
   function automatic logic [31:0] axis_key(point_type p, logic [1:0] ax);
      logic [31:0] v;
      case (ax)
         2'd0:    v = p.x;
         2'd1:    v = p.y;
         default: v = p.z;
      endcase
      return v ^ 32'h8000_0000;
   endfunction

endpackage

FILE: sv/aqtf_store.sv
// ---------------------------------------------------------------------------
// aqtf_store
// Point memory: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module aqtf_store #(
   parameter int MAX_POINTS = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   input  aqtf_pkg::point_type           wr_data,
   input  logic [$clog2(MAX_POINTS)-1:0] rd_a_addr,
   output aqtf_pkg::point_type           rd_a_data,
   input  logic [$clog2(MAX_POINTS)-1:0] rd_b_addr,
   output aqtf_pkg::point_type           rd_b_data
);

   aqtf_pkg::point_type mem [MAX_POINTS];

   // Synchronous write and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

FILE: sv/axis_quantile_trim_filter_core.sv
// ---------------------------------------------------------------------------
// axis_quantile_trim_filter_core
// Quantile trim of a point cloud along one configured axis.
// ---------------------------------------------------------------------------
// Points are loaded one beat per cycle while in the load state, into a
// memory of MAX_POINTS entries. On the beat with tlast the block computes
// k = floor(N * keep_ratio / 2^16) and finds the k-th smallest coordinate
// by rank counting: for each candidate i it sweeps all N entries through
// the second memory read port. It then sweeps the store once more,
// emitting in input order every point strictly below the limit. Each kept
// point that follows another adds the output handshake and a reread. No beat
// is accepted from the end of a cloud until its last result has been taken.
// ---------------------------------------------------------------------------
module axis_quantile_trim_filter_core #(
   parameter int MAX_POINTS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata: coord_x, coord_y, coord_z, point_tag (lowest bit up)
   input  logic [127:0]  req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata: out_x, out_y, out_z, out_tag (lowest bit up)
   output logic [127:0]  rsp_tdata,
   output logic          rsp_tlast,
   // tuser: none_kept, overflowed (lowest bit up)
   output logic [1:0]    rsp_tuser,
   input  logic          csr_wr_en,
   input  logic [0:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [2:0] {
      S_LOAD, S_CAND, S_SCAN, S_EMIT_RD, S_EMIT, S_OUT
   } state_type;

   state_type  state_ff;
   logic [1:0]  axis_ff;
   logic [15:0] ratio_ff;
   logic [CW-1:0] count_ff;
   logic          ovf_ff;
   logic [1:0]    ax_ff;
   logic [CW-1:0] k_ff;
   logic [AW-1:0] ci_ff;      // candidate index
   logic [CW-1:0] sj_ff;      // scan read counter
   logic          sv_ff;      // scan read data valid
   logic [CW-1:0] less_ff, lesseq_ff;
   logic [31:0]   cand_ff, limit_ff;
   logic [CW-1:0] ei_ff;
   logic          pend_ff;
   logic [127:0]  odata_ff;
   logic          olast_ff, onone_ff;

   logic          wr_en;
   aqtf_pkg::point_type rd_a, rd_b, wr_pt;
   logic [AW-1:0] rd_a_addr, rd_b_addr;
   logic [31:0]   key_b;
   logic [CW-1:0] count_in;
   logic [CW+15:0] prod;
   logic [CW-1:0] less_in, lesseq_in;

   assign wr_pt     = aqtf_pkg::point_type'(req_tdata);
   assign req_tready = (state_ff == S_LOAD);
   assign wr_en     = req_tvalid && req_tready && (count_ff < CW'(MAX_POINTS));
   assign count_in  = wr_en ? count_ff + 1'b1 : count_ff;
   assign rd_a_addr = (state_ff == S_EMIT_RD || state_ff == S_EMIT) ?
                      ei_ff[AW-1:0] : ci_ff;
   assign rd_b_addr = sj_ff[AW-1:0];
   assign key_b     = aqtf_pkg::axis_key(rd_b, ax_ff);
   // k is taken over the count that includes the final point.
   assign prod      = count_in * ratio_ff;
   assign less_in   = less_ff + CW'(key_b < cand_ff);
   assign lesseq_in = lesseq_ff + CW'(key_b <= cand_ff);

   aqtf_store #(.MAX_POINTS(MAX_POINTS)) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[AW-1:0]),
      .wr_data  (wr_pt),
      .rd_a_addr(rd_a_addr),
      .rd_a_data(rd_a),
      .rd_b_addr(rd_b_addr),
      .rd_b_data(rd_b)
   );

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = {ovf_ff, onone_ff};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff  <= 2'd0;
         ratio_ff <= aqtf_pkg::RATIO_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            aqtf_pkg::REG_AXIS:  axis_ff  <= csr_wdata[1:0];
            aqtf_pkg::REG_RATIO: ratio_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Load, select and emit sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         sv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (req_tvalid) begin
                  count_ff <= count_in;
                  if (!wr_en) ovf_ff <= 1'b1;
                  if (req_tlast) begin
                     ax_ff   <= (axis_ff == 2'd3) ? 2'd2 : axis_ff;
                     k_ff    <= prod[CW+15:16];
                     ci_ff   <= '0;
                     pend_ff <= 1'b0;
                     state_ff <= S_CAND;
                  end
               end
            end
            S_CAND: begin
               // count_ff holds N; k_ff < N always holds for N > 0.
               if (count_ff == '0) begin
                  ei_ff    <= '0;
                  state_ff <= S_EMIT_RD;
                  limit_ff <= '0;
               end else begin
                  // Read data for candidate arrives next cycle.
                  sj_ff     <= '0;
                  sv_ff     <= 1'b0;
                  less_ff   <= '0;
                  lesseq_ff <= '0;
                  state_ff  <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (!sv_ff && sj_ff == '0) begin
                  cand_ff <= aqtf_pkg::axis_key(rd_a, ax_ff);
                  sj_ff   <= sj_ff + 1'b1;
                  sv_ff   <= 1'b1;
               end else begin
                  less_ff   <= less_in;
                  lesseq_ff <= lesseq_in;
                  if (sj_ff == count_ff) begin
                     if (less_in <= k_ff && k_ff < lesseq_in) begin
                        limit_ff <= cand_ff;
                        ei_ff    <= '0;
                        state_ff <= S_EMIT_RD;
                     end else begin
                        ci_ff    <= ci_ff + 1'b1;
                        state_ff <= S_CAND;
                     end
                     sv_ff <= 1'b0;
                  end else begin
                     sj_ff <= sj_ff + 1'b1;
                  end
               end
            end
            S_EMIT_RD: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               // rd_a holds entry ei_ff; a kept point is held back one
               // step so that the last one can carry tlast.
               if (ei_ff == count_ff) begin
                  olast_ff <= 1'b1;
                  if (pend_ff) begin
                     onone_ff <= 1'b0;
                  end else begin
                     odata_ff <= '0;
                     onone_ff <= 1'b1;
                  end
                  pend_ff  <= 1'b0;
                  state_ff <= S_OUT;
               end else begin
                  ei_ff <= ei_ff + 1'b1;
                  if (aqtf_pkg::axis_key(rd_a, ax_ff) < limit_ff) begin
                     if (pend_ff) begin
                        // Current held point goes out; the new one is
                        // reread after.
                        olast_ff <= 1'b0;
                        onone_ff <= 1'b0;
                        pend_ff  <= 1'b0;
                        state_ff <= S_OUT;
                     end else begin
                        odata_ff <= rd_a;
                        pend_ff  <= 1'b1;
                        state_ff <= S_EMIT_RD;
                     end
                  end else begin
                     state_ff <= S_EMIT_RD;
                  end
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  if (olast_ff) begin
                     count_ff <= '0;
                     ovf_ff   <= 1'b0;
                     state_ff <= S_LOAD;
                  end else begin
                     // Entry ei_ff-1 is the next held point; reread it.
                     ei_ff    <= ei_ff - 1'b1;
                     state_ff <= S_EMIT_RD;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

endmodule

FILE: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the quantile trim filter core.
// ---------------------------------------------------------------------------
// A queue of point beats feeds a clocked driver. A predictor keeps its own
// copy of the point store and the registers. On each last point it works out
// the kept points in input order. A clocked monitor compares every result
// beat with the oldest prediction. Clouds run under several settings of the
// axis and the keep ratio, the extremes among them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int CAPACITY = 64;

   typedef struct {
      logic [127:0] data;
      logic         last;
   } point_beat_type;

   typedef struct {
      logic [127:0] data;
      logic         last;
      logic [1:0]   user;
   } kept_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tlast;
   logic [1:0]   rsp_tuser;
   logic         csr_wr_en = 1'b0;
   logic [0:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   point_beat_type pending_points[$];
   kept_beat_type  kept_queue[$];
   int        fail_count = 0;
   bit        quiet_phase = 1'b0;

   // Predictor state.
   aqtf_pkg::point_type cloud_store[CAPACITY];
   int        cloud_count = 0;
   bit        cloud_dropped = 1'b0;
   logic [1:0]  trim_axis = 2'd0;
   logic [15:0] trim_ratio = aqtf_pkg::RATIO_RESET;

   axis_quantile_trim_filter_core #(.MAX_POINTS(CAPACITY)) dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [31:0] coord_key(aqtf_pkg::point_type p, logic [1:0] ax);
      logic [31:0] c;
      c = (ax == 2'd0) ? p.x : (ax == 2'd1) ? p.y : p.z;
      return c ^ 32'h8000_0000;
   endfunction

   // Store one point and, on the last one, predict the kept points.
   task automatic predict_point(point_beat_type b);
      logic [1:0]  ax;
      logic [31:0] limit, v;
      int          k, less, lesseq, kept;
      logic [63:0] prod;
      kept_beat_type r;
      if (cloud_count < CAPACITY) begin
         cloud_store[cloud_count] = b.data;
         cloud_count++;
      end else begin
         cloud_dropped = 1'b1;
      end
      if (!b.last) return;
      ax = (trim_axis > 2'd2) ? 2'd2 : trim_axis;
      prod = 64'(cloud_count) * 64'(trim_ratio);
      k = int'(prod >> 16);
      kept = 0;
      if (k < cloud_count) begin
         limit = coord_key(cloud_store[0], ax);
         for (int i = 0; i < cloud_count; i++) begin
            v = coord_key(cloud_store[i], ax);
            less = 0;
            lesseq = 0;
            for (int j = 0; j < cloud_count; j++) begin
               if (coord_key(cloud_store[j], ax) < v) less++;
               if (coord_key(cloud_store[j], ax) <= v) lesseq++;
            end
            if (less <= k && k < lesseq) begin
               limit = v;
               break;
            end
         end
         for (int i = 0; i < cloud_count; i++) begin
            if (coord_key(cloud_store[i], ax) < limit) begin
               r.data = cloud_store[i];
               r.last = 1'b0;
               r.user = {cloud_dropped, 1'b0};
               kept_queue.insert(kept_queue.size(), r);
               kept++;
            end
         end
      end
      if (kept == 0) begin
         r.data = '0;
         r.last = 1'b1;
         r.user = {cloud_dropped, 1'b1};
         kept_queue.insert(kept_queue.size(), r);
      end else begin
         kept_queue[$].last = 1'b1;
      end
      cloud_count = 0;
      cloud_dropped = 1'b0;
   endtask

   // Driver: one point beat per handshake, with random gaps.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_point('{req_tdata, req_tlast});
         end
         if ((!req_tvalid || req_tready)) begin
            if (pending_points.size() > 0 && (quiet_phase || $urandom_range(99) >= 9)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_points[0].data;
               req_tlast  <= pending_points[0].last;
               void'(pending_points.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result beat with the oldest prediction.
   always @(posedge clock) begin
      kept_beat_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (kept_queue.size() == 0) begin
               $display("%0t: unexpected result data=%h last=%b user=%b", $time,
                        rsp_tdata, rsp_tlast, rsp_tuser);
               fail_count++;
            end else begin
               e = kept_queue.pop_front();
               if (rsp_tdata !== e.data) begin
                  $display("%0t: data expected %h actual %h", $time, e.data, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $display("%0t: last expected %b actual %b", $time, e.last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== e.user) begin
                  $display("%0t: user expected %b actual %b", $time, e.user, rsp_tuser);
                  fail_count++;
               end
            end
         end
         rsp_tready <= quiet_phase || ($urandom_range(99) >= 9);
      end
   end

   task automatic write_reg(logic [0:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == aqtf_pkg::REG_AXIS) trim_axis = value[1:0];
      else trim_ratio = value;
   endtask

   // Wait until every queued point is taken and every result has come.
   // The check runs on the falling edge, clear of the driver's updates.
   task automatic drain();
      @(negedge clock);
      while (pending_points.size() > 0 || req_tvalid || kept_queue.size() > 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(7);
         default: return 32'h8000_0000 + $urandom_range(3) - 2;
      endcase
   endfunction

   task automatic queue_cloud(int n, int mode);
      point_beat_type b;
      for (int i = 0; i < n; i++) begin
         b.data = {32'($urandom), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
         b.last = (i == n - 1);
         pending_points.push_back(b);
      end
   endtask

   initial begin
      point_beat_type b;
      int sent;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, ties, a single point, overflow.
      write_reg(aqtf_pkg::REG_AXIS, 16'd0);
      write_reg(aqtf_pkg::REG_RATIO, 16'd65535);
      b.data = {32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      b.last = 0; pending_points.push_back(b);
      b.data = {32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      b.last = 0; pending_points.push_back(b);
      b.data = {32'h1234_5678, 32'h0, 32'h0, 32'hFFFF_FFFF};
      b.last = 0; pending_points.push_back(b);
      b.data = {32'h5555_AAAA, 32'h0, 32'h0, 32'hFFFF_FFFF};
      b.last = 1; pending_points.push_back(b);
      drain();
      write_reg(aqtf_pkg::REG_RATIO, 16'd1);
      queue_cloud(3, 1);
      queue_cloud(1, 0);
      drain();
      write_reg(aqtf_pkg::REG_AXIS, 16'd3);
      write_reg(aqtf_pkg::REG_RATIO, 16'd32768);
      queue_cloud(5, 1);
      drain();
      write_reg(aqtf_pkg::REG_AXIS, 16'd1);
      queue_cloud(CAPACITY + 2, 2);
      drain();

      // Random clouds under changing settings.
      sent = 0;
      while (sent < 70) begin
         int n;
         write_reg(aqtf_pkg::REG_AXIS, 16'($urandom_range(3)));
         write_reg(aqtf_pkg::REG_RATIO, ($urandom_range(3) == 0) ? 16'd65535 :
                   16'($urandom_range(65535, 1)));
         n = ($urandom_range(9) == 0) ? $urandom_range(CAPACITY + 3, 40) : $urandom_range(12, 1);
         quiet_phase = (sent >= 20 && sent < 50);
         queue_cloud(n, $urandom_range(2));
         sent += n;
         drain();
      end
      quiet_phase = 1'b0;

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/aqtf_pkg.sv
sv/aqtf_store.sv
sv/axis_quantile_trim_filter_core.sv
test/testbench.sv
